// ----- rtl/wbps_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbps_pkg
// shared constants and types of the wildcard byte pattern scanner
// ----------------------------------------------------------------------------
package wbps_pkg;

  localparam int MAX_PATTERN   = 32;
  localparam int PAT_IDX_W     = $clog2(MAX_PATTERN);
  localparam int OFFSET_BITS   = 32;
  localparam int OUT_OFF_W     = 32;
  localparam int CNT_W         = 3;
  localparam int LEN_W         = 6;
  localparam int CARE_W        = 32;
  localparam int NUM_PAT_WORDS = 4;
  localparam int CFG_DATA_W    = 64;
  localparam int CFG_ADDR_W    = 6;
  localparam int REG_SEL_W     = 3;

  localparam logic [CNT_W-1:0] HIT_CAP = CNT_W'(4);

  typedef enum logic [REG_SEL_W-1:0] {
    REG_PAT_WORD0,
    REG_PAT_WORD1,
    REG_PAT_WORD2,
    REG_PAT_WORD3,
    REG_CARE_MASK,
    REG_PAT_LEN
  } cfg_reg_t;

  // pattern turned around so that entry j lines up with window entry j
  typedef struct packed {
    logic [MAX_PATTERN-1:0][7:0] pat;
    logic [MAX_PATTERN-1:0]      care;
    logic [PAT_IDX_W-1:0]        len_m1;
    logic                        usable;
  } match_cfg_t;

  typedef struct packed {
    logic [MAX_PATTERN-1:0][7:0] window;
    logic [OFFSET_BITS-1:0]      here;
    logic                        last;
  } scan_item_t;

endpackage

// ----- rtl/wbps_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbps_in_if / wbps_out_if
// valid/ready channels for the scanned bytes and the per-byte results
// ----------------------------------------------------------------------------
interface wbps_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface wbps_out_if;
  logic        valid;
  logic        ready;
  logic        hit_now;
  logic [31:0] hit_start;
  logic [2:0]  hit_total;
  logic        unique_found;
  logic [31:0] unique_start;
  logic        region_done;

  modport source (
    output valid, output hit_now, output hit_start, output hit_total,
    output unique_found, output unique_start, output region_done, input ready
  );
  modport sink (
    input valid, input hit_now, input hit_start, input hit_total,
    input unique_found, input unique_start, input region_done, output ready
  );
endinterface

// ----- rtl/wbps_cfg_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbps_cfg_regs
// apb register file and registered alignment of the pattern to the window
// ----------------------------------------------------------------------------
module wbps_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [wbps_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [wbps_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [wbps_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                             pready,
  output wbps_pkg::match_cfg_t             mcfg
);
  import wbps_pkg::*;

  logic [NUM_PAT_WORDS-1:0][CFG_DATA_W-1:0] pat_word_r;
  logic [CARE_W-1:0]                        care_r;
  logic [LEN_W-1:0]                         len_r;
  logic [MAX_PATTERN-1:0][7:0]              pat_bytes;
  cfg_reg_t                                 reg_sel;
  logic                                     wr_en;
  match_cfg_t                               mcfg_r;
  match_cfg_t                               mcfg_nxt;
  logic [LEN_W-1:0]                         src;
  logic                                     in_use;

  assign pready    = 1'b1;
  assign reg_sel   = cfg_reg_t'(paddr[CFG_ADDR_W-1:CFG_ADDR_W-REG_SEL_W]);
  assign wr_en     = psel & penable & pwrite;
  assign pat_bytes = pat_word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_word_r <= '0;
      care_r     <= '0;
      len_r      <= '0;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_PAT_WORD0: pat_word_r[0] <= pwdata;
        REG_PAT_WORD1: pat_word_r[1] <= pwdata;
        REG_PAT_WORD2: pat_word_r[2] <= pwdata;
        REG_PAT_WORD3: pat_word_r[3] <= pwdata;
        REG_CARE_MASK: care_r        <= pwdata[CARE_W-1:0];
        REG_PAT_LEN:   len_r         <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_PAT_WORD0: prdata = pat_word_r[0];
      REG_PAT_WORD1: prdata = pat_word_r[1];
      REG_PAT_WORD2: prdata = pat_word_r[2];
      REG_PAT_WORD3: prdata = pat_word_r[3];
      REG_CARE_MASK: prdata = CFG_DATA_W'(care_r);
      REG_PAT_LEN:   prdata = CFG_DATA_W'(len_r);
      default:       prdata = '0;
    endcase
  end

  // window entry j (newest first) meets pattern byte len-1-j
  always_comb begin
    mcfg_nxt = '0;
    src      = '0;
    in_use   = 1'b0;
    for (int j = 0; j < MAX_PATTERN; j++) begin
      src              = LEN_W'(len_r - LEN_W'(j) - LEN_W'(1));
      in_use           = LEN_W'(j) < len_r;
      mcfg_nxt.pat[j]  = pat_bytes[src[PAT_IDX_W-1:0]];
      mcfg_nxt.care[j] = in_use & care_r[src[PAT_IDX_W-1:0]];
    end
    mcfg_nxt.len_m1 = PAT_IDX_W'(len_r - LEN_W'(1));
    mcfg_nxt.usable = (len_r != '0) && (len_r <= LEN_W'(MAX_PATTERN)) && (|mcfg_nxt.care);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mcfg_r <= '0;
    end else begin
      mcfg_r <= mcfg_nxt;
    end
  end

  assign mcfg = mcfg_r;

endmodule

// ----- rtl/wbps_window.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbps_window
// input stage: byte window shift register and region offset counter
// ----------------------------------------------------------------------------
module wbps_window (
  input  logic                 clk,
  input  logic                 rst_n,
  wbps_in_if.sink              in_ch,
  input  logic                 take,
  output logic                 s1_valid,
  output wbps_pkg::scan_item_t s1_item
);
  import wbps_pkg::*;

  logic                        s1_v_r;
  logic [OFFSET_BITS-1:0]      seen_r;
  logic [OFFSET_BITS-1:0]      seen_nxt;
  logic [MAX_PATTERN-1:0][7:0] window_r;
  logic [OFFSET_BITS-1:0]      here_r;
  logic                        last_r;
  logic                        acc;

  assign in_ch.ready = !s1_v_r || take;
  assign acc         = in_ch.valid && in_ch.ready;

  // offset saturates at all ones, restarts after the last byte
  always_comb begin
    if (in_ch.last_byte) begin
      seen_nxt = '0;
    end else if (seen_r != '1) begin
      seen_nxt = seen_r + OFFSET_BITS'(1);
    end else begin
      seen_nxt = seen_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r   <= 1'b0;
      seen_r   <= '0;
      window_r <= '0;
    end else begin
      if (acc) begin
        s1_v_r   <= 1'b1;
        seen_r   <= seen_nxt;
        window_r <= {window_r[MAX_PATTERN-2:0], in_ch.data_byte};
      end else if (take) begin
        s1_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      here_r <= seen_r;
      last_r <= in_ch.last_byte;
    end
  end

  assign s1_valid       = s1_v_r;
  assign s1_item.window = window_r;
  assign s1_item.here   = here_r;
  assign s1_item.last   = last_r;

  property p_hold_stalled;
    @(posedge clk) disable iff (!rst_n)
      (s1_v_r && !take) |=> (s1_v_r && $stable(here_r) && $stable(last_r));
  endproperty
  a_hold_stalled: assert property (p_hold_stalled)
    else $error("input stage lost a request while stalled");

  property p_offset_restart;
    @(posedge clk) disable iff (!rst_n)
      (acc && in_ch.last_byte) |=> (seen_r == '0);
  endproperty
  a_offset_restart: assert property (p_offset_restart)
    else $error("offset did not restart after region end");

endmodule

// ----- rtl/wbps_match.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbps_match
// window compare, hit counting and the result register
// ----------------------------------------------------------------------------
module wbps_match (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 s1_valid,
  input  wbps_pkg::scan_item_t s1_item,
  input  wbps_pkg::match_cfg_t mcfg,
  output logic                 take,
  wbps_out_if.source           out_ch
);
  import wbps_pkg::*;

  logic                   out_v_r;
  logic [CNT_W-1:0]       cnt_r;
  logic [CNT_W-1:0]       cnt_nxt;
  logic [OFFSET_BITS-1:0] fs_r;
  logic [OFFSET_BITS-1:0] fs_nxt;
  logic [MAX_PATTERN-1:0] byte_ok;
  logic                   hit;
  logic [OFFSET_BITS-1:0] start;

  logic                   hit_now_r;
  logic [OUT_OFF_W-1:0]   hit_start_r;
  logic [CNT_W-1:0]       hit_total_r;
  logic                   unique_found_r;
  logic [OUT_OFF_W-1:0]   unique_start_r;
  logic                   region_done_r;

  assign take = s1_valid && (!out_v_r || out_ch.ready);

  always_comb begin
    for (int j = 0; j < MAX_PATTERN; j++) begin
      byte_ok[j] = !mcfg.care[j] || (s1_item.window[j] == mcfg.pat[j]);
    end
    hit   = mcfg.usable && (s1_item.here >= OFFSET_BITS'(mcfg.len_m1)) && (&byte_ok);
    start = hit ? (s1_item.here - OFFSET_BITS'(mcfg.len_m1)) : '0;
    cnt_nxt = (hit && (cnt_r < HIT_CAP)) ? cnt_r + CNT_W'(1) : cnt_r;
    fs_nxt  = (hit && (cnt_r == '0)) ? start : fs_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      cnt_r   <= '0;
      fs_r    <= '0;
    end else begin
      if (take) begin
        out_v_r <= 1'b1;
        cnt_r   <= s1_item.last ? '0 : cnt_nxt;
        fs_r    <= s1_item.last ? '0 : fs_nxt;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      hit_now_r      <= hit;
      hit_start_r    <= OUT_OFF_W'(start);
      hit_total_r    <= cnt_nxt;
      unique_found_r <= cnt_nxt == CNT_W'(1);
      unique_start_r <= (cnt_nxt == CNT_W'(1)) ? OUT_OFF_W'(fs_nxt) : '0;
      region_done_r  <= s1_item.last;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.hit_now      = hit_now_r;
  assign out_ch.hit_start    = hit_start_r;
  assign out_ch.hit_total    = hit_total_r;
  assign out_ch.unique_found = unique_found_r;
  assign out_ch.unique_start = unique_start_r;
  assign out_ch.region_done  = region_done_r;

  property p_cnt_cap;
    @(posedge clk) disable iff (!rst_n)
      cnt_r <= HIT_CAP;
  endproperty
  a_cnt_cap: assert property (p_cnt_cap)
    else $error("hit count above cap");

  property p_unique_total;
    @(posedge clk) disable iff (!rst_n)
      (out_v_r && unique_found_r) |-> (hit_total_r == CNT_W'(1));
  endproperty
  a_unique_total: assert property (p_unique_total)
    else $error("unique flag without a single hit");

  property p_no_hit_start;
    @(posedge clk) disable iff (!rst_n)
      (out_v_r && !hit_now_r) |-> (hit_start_r == '0);
  endproperty
  a_no_hit_start: assert property (p_no_hit_start)
    else $error("start offset without a hit");

  property p_region_clear;
    @(posedge clk) disable iff (!rst_n)
      (take && s1_item.last) |=> ((cnt_r == '0) && (fs_r == '0));
  endproperty
  a_region_clear: assert property (p_region_clear)
    else $error("region state not cleared after last byte");

endmodule

// ----- rtl/wildcard_byte_pattern_scanner.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scanner
// scans a byte stream for a pattern of up to 32 exact or wildcard bytes
// ----------------------------------------------------------------------------
// in_ch carries one byte of the region per request, last_byte on the final
// one. out_ch returns one result per byte: whether a match ends there and
// where it starts, the hit count so far (saturating at 4) and the start of
// the first hit while it is the only one. region_done marks the result of
// the last byte, after which offset, count and first start restart at zero.
// Pattern, care mask and length are written over the apb port at 8*index
// and must only change while no byte is in flight.
// A result passes through the input register holding the window, then the
// compare into the result register. Throughput: one byte per cycle while
// out_ch does not stall, set by the single compare of all window bytes
// between those two registers.
// When out_ch stalls, the result register and the input stage each hold one
// request, then in_ch deasserts ready until the receiver takes a result.
// Reset clears registers, window, offset and counts and empties both stages.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_scanner (
  input  logic                            clk,
  input  logic                            rst_n,
  wbps_in_if.sink                         in_ch,
  wbps_out_if.source                      out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [wbps_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [wbps_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [wbps_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);
  import wbps_pkg::*;

  match_cfg_t mcfg;
  scan_item_t s1_item;
  logic       s1_valid;
  logic       take;

  wbps_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .mcfg    (mcfg)
  );

  wbps_window u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .take     (take),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  wbps_match u_match (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_valid (s1_valid),
    .s1_item  (s1_item),
    .mcfg     (mcfg),
    .take     (take),
    .out_ch   (out_ch)
  );

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking testbench of the wildcard byte pattern scanner
// ----------------------------------------------------------------------------
// Bytes go in over the input channel, and the testbench keeps its own copy of
// the byte window, the region offset, the hit count and the first hit start.
// From these it computes the result due for every accepted byte. Each result
// that comes out is checked field by field against the oldest one still
// outstanding. The directed tests cover these cases: an empty pattern, a
// wildcard byte inside the pattern, a region too short to hold a match,
// overlapping hits, a hit on the last byte, a saturated hit count, a pattern
// made only of wildcards and an overlong length. After them come random
// phases. Each phase has its own pattern setup and one of four mixes of
// sender idling and receiver stalls. Most regions carry planted copies of
// the pattern, some of them corrupted. The registers are also read back
// over the apb port.
// ----------------------------------------------------------------------------
module tb_top;
  import wbps_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;

  typedef struct packed {
    logic        hit_now;
    logic [31:0] hit_start;
    logic [2:0]  hit_total;
    logic        unique_found;
    logic [31:0] unique_start;
    logic        region_done;
  } scan_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  wbps_in_if  in_ch ();
  wbps_out_if out_ch ();

  wildcard_byte_pattern_scanner u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predictor copy of registers and region state
  logic [63:0]            pat_word [NUM_PAT_WORDS];
  logic [CARE_W-1:0]      care_bits;
  logic [LEN_W-1:0]       pat_len;
  logic [7:0]             win [MAX_PATTERN];
  logic [OFFSET_BITS-1:0] offset_now;
  logic [CNT_W-1:0]       hits_in_region;
  logic [OFFSET_BITS-1:0] first_hit_start;

  scan_result_t expected_q [$];

  int   err_cnt = 0;
  int   bytes_sent = 0;
  int   hits_seen = 0;
  int   regions_seen = 0;
  int   stall_cycles = 0;
  int   in_gap_pct = 0;
  int   out_stall_pct = 0;
  logic [7:0] alpha_a;
  logic [7:0] alpha_b;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [7:0] pat_byte(int k);
    return pat_word[k / 8][8 * (k % 8) +: 8];
  endfunction

  function automatic void clear_region();
    foreach (win[i]) win[i] = '0;
    offset_now      = '0;
    hits_in_region  = '0;
    first_hit_start = '0;
  endfunction

  function automatic void predict_byte(logic [7:0] d, logic l);
    scan_result_t           r;
    int                     len;
    logic                   hit;
    logic [31:0]            used;
    logic [OFFSET_BITS-1:0] start;
    for (int i = MAX_PATTERN - 1; i > 0; i--) win[i] = win[i - 1];
    win[0] = d;
    len  = int'(pat_len);
    used = (len >= 32) ? '1 : ((32'd1 << len) - 32'd1);
    hit  = (len != 0) && (len <= MAX_PATTERN) && ((care_bits & used) != '0);
    hit  = hit && (offset_now >= OFFSET_BITS'(len - 1));
    for (int i = 0; i < len && hit; i++) begin
      if (care_bits[i] && win[len - 1 - i] !== pat_byte(i)) hit = 1'b0;
    end
    start = hit ? offset_now - OFFSET_BITS'(len - 1) : '0;
    if (hit) begin
      if (hits_in_region == '0) first_hit_start = start;
      if (hits_in_region < HIT_CAP) hits_in_region++;
    end
    if (offset_now != '1) offset_now++;
    r.hit_now      = hit;
    r.hit_start    = start[31:0];
    r.hit_total    = hits_in_region;
    r.unique_found = (hits_in_region == CNT_W'(1));
    r.unique_start = r.unique_found ? first_hit_start[31:0] : '0;
    r.region_done  = l;
    expected_q.push_back(r);
    if (l) clear_region();
  endfunction

  function automatic logic [63:0] reg_model(cfg_reg_t idx);
    case (idx)
      REG_CARE_MASK: return 64'(care_bits);
      REG_PAT_LEN:   return 64'(pat_len);
      default:       return pat_word[int'(idx)];
    endcase
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      err_cnt++;
    end
  endfunction

  function automatic logic [7:0] pick_byte(logic narrow);
    if (narrow) return $urandom_range(0, 1) ? alpha_a : alpha_b;
    return 8'($urandom);
  endfunction

  // result checker
  always @(posedge clk) begin
    scan_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        $error("result request with no byte outstanding");
        err_cnt++;
      end else begin
        want = expected_q.pop_front();
        check_field("hit_now", 64'(want.hit_now), 64'(out_ch.hit_now));
        check_field("hit_start", 64'(want.hit_start), 64'(out_ch.hit_start));
        check_field("hit_total", 64'(want.hit_total), 64'(out_ch.hit_total));
        check_field("unique_found", 64'(want.unique_found), 64'(out_ch.unique_found));
        check_field("unique_start", 64'(want.unique_start), 64'(out_ch.unique_start));
        check_field("region_done", 64'(want.region_done), 64'(out_ch.region_done));
      end
      if (out_ch.hit_now) hits_seen++;
      if (out_ch.region_done) regions_seen++;
    end
  end

  // receiver stalls
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(0, 99) >= out_stall_pct);
    end
  end

  // watchdog on cycles without any accepted request
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("wildcard_byte_pattern_scanner: mismatch");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] d, input logic l);
    while ($urandom_range(0, 99) < in_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= d;
    in_ch.last_byte <= l;
    do @(posedge clk); while (!in_ch.ready);
    predict_byte(d, l);
    bytes_sent++;
  endtask

  task automatic send_region(input logic [7:0] region_bytes [$]);
    foreach (region_bytes[i]) send_byte(region_bytes[i], i == region_bytes.size() - 1);
  endtask

  // drain all results, then let the pipeline empty
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'(8 * int'(idx));
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_CARE_MASK: care_bits = value[CARE_W-1:0];
      REG_PAT_LEN:   pat_len = value[LEN_W-1:0];
      default:       pat_word[int'(idx)] = value;
    endcase
    @(posedge clk);
  endtask

  task automatic read_check(input cfg_reg_t idx);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= CFG_ADDR_W'(8 * int'(idx));
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    check_field($sformatf("prdata of register %0d", int'(idx)), reg_model(idx), prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_registers();
    for (int i = int'(REG_PAT_WORD0); i <= int'(REG_PAT_LEN); i++) read_check(cfg_reg_t'(i));
  endtask

  task automatic load_pattern(input logic [63:0] w0, input logic [63:0] w1,
                              input logic [63:0] w2, input logic [63:0] w3,
                              input logic [31:0] care, input logic [5:0] len);
    settle();
    write_reg(REG_PAT_WORD0, w0);
    write_reg(REG_PAT_WORD1, w1);
    write_reg(REG_PAT_WORD2, w2);
    write_reg(REG_PAT_WORD3, w3);
    write_reg(REG_CARE_MASK, 64'(care));
    write_reg(REG_PAT_LEN, 64'(len));
  endtask

  task automatic test_register_access();
    check_registers();
    load_pattern('1, '1, '1, '1, '1, '1);
    check_registers();
    load_pattern('0, '0, '0, '0, '0, '0);
    check_registers();
  endtask

  task automatic test_empty_pattern();
    send_region('{8'h00, 8'hFF});
  endtask

  // pattern 00 ?? ff
  task automatic test_wildcard_middle();
    load_pattern(64'h0000_0000_00FF_7700, '0, '0, '0, 32'h5, 6'd3);
    send_region('{8'h00, 8'hFF});
    send_region('{8'h00, 8'h00, 8'hFF, 8'hFF});
    send_region('{8'h5A, 8'h00, 8'hC3, 8'hFF});
  endtask

  task automatic test_hit_saturation();
    load_pattern(64'hAA, '0, '0, '0, 32'h1, 6'd1);
    send_region('{8'hAA, 8'hAA, 8'hAA, 8'hAA, 8'hAA, 8'hAA});
  endtask

  task automatic test_all_wildcards();
    load_pattern(64'h3322_1100, '0, '0, '0, 32'hFFFF_FFF0, 6'd4);
    send_region('{8'h11, 8'h22, 8'h33});
  endtask

  task automatic test_overlong_length();
    load_pattern('0, '0, '0, '0, '1, 6'd33);
    send_region('{8'h00, 8'h00});
    load_pattern('0, '0, '0, '0, '1, 6'd63);
    send_region('{8'h00});
  endtask

  // region with zero to two planted copies, some with one flipped bit
  task automatic send_random_region(input logic narrow);
    logic [7:0] region_bytes [$];
    int         len;
    int         rlen;
    int         pos;
    int         copies;
    len    = int'(pat_len);
    copies = 0;
    if (len >= 1 && len <= MAX_PATTERN && $urandom_range(0, 99) < 75)
      copies = $urandom_range(1, 2);
    if (copies != 0) rlen = len + $urandom_range(0, 10);
    else if ($urandom_range(0, 19) == 0) rlen = $urandom_range(17, 70);
    else rlen = $urandom_range(1, 16);
    for (int i = 0; i < rlen; i++) region_bytes.push_back(pick_byte(narrow));
    for (int c = 0; c < copies; c++) begin
      pos = $urandom_range(0, rlen - len);
      for (int i = 0; i < len; i++) begin
        if (care_bits[i]) region_bytes[pos + i] = pat_byte(i);
      end
      if ($urandom_range(0, 99) < 15)
        region_bytes[pos + $urandom_range(0, len - 1)] ^= 8'h01 << $urandom_range(0, 7);
    end
    send_region(region_bytes);
  endtask

  task automatic test_random_scan();
    logic [63:0] words [NUM_PAT_WORDS];
    logic [31:0] care;
    int          len;
    logic        narrow;
    int          first;
    for (int p = 0; p < 8; p++) begin
      narrow  = (p == 0 || p == 6);
      alpha_a = 8'($urandom);
      alpha_b = (p == 6) ? ~alpha_a : 8'($urandom);
      for (int k = 0; k < MAX_PATTERN; k++) words[k / 8][8 * (k % 8) +: 8] = pick_byte(narrow);
      care = $urandom;
      case (p)
        0: begin
          len  = 1;
          care = 32'h1;
        end
        1: begin
          len  = 32;
          care = '1;
        end
        2: len = $urandom_range(2, 31);
        3: begin
          len  = 0;
          care = '1;
          foreach (words[w]) words[w] = '1;
        end
        4: len = $urandom_range(33, 63);
        5: begin
          len  = $urandom_range(1, 31);
          care = care & ~((32'd1 << len) - 32'd1);
        end
        6: len = $urandom_range(1, 8);
        default: begin
          len = 32;
          foreach (words[w]) words[w] = '0;
        end
      endcase
      load_pattern(words[0], words[1], words[2], words[3], care, 6'(len));
      case (p % 4)
        0: begin in_gap_pct = 0;  out_stall_pct = 0;  end
        1: begin in_gap_pct = 74; out_stall_pct = 0;  end
        2: begin in_gap_pct = 0;  out_stall_pct = 74; end
        default: begin in_gap_pct = 36; out_stall_pct = 36; end
      endcase
      first = bytes_sent;
      while (bytes_sent - first < 105) send_random_region(narrow);
    end
  endtask

  initial begin
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.data_byte <= '0;
    in_ch.last_byte <= 1'b0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    foreach (pat_word[w]) pat_word[w] = '0;
    care_bits = '0;
    pat_len   = '0;
    clear_region();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_register_access();
    test_empty_pattern();
    test_wildcard_middle();
    test_hit_saturation();
    test_all_wildcards();
    test_overlong_length();
    test_random_scan();

    settle();
    repeat (8) @(posedge clk);
    $display("scanned %0d bytes in %0d regions, %0d results reported a hit",
             bytes_sent, regions_seen, hits_seen);
    $display("lengths 0 to 63, exact and wildcard masks, four idling mixes, register readback");
    if (err_cnt == 0) begin
      $display("wildcard_byte_pattern_scanner: match");
    end else begin
      $display("wildcard_byte_pattern_scanner: mismatch");
    end
    $finish;
  end

endmodule
